[rtl/core/pdu_pkg.sv]
// pdu_pkg: shared types and constants of the planar distance unit
// metric codes, datapath widths and the sideband carried through the root pipeline
// no dependencies
`timescale 1ns / 1ps

package pdu_pkg;

    localparam int COORD_W = 24;               // signed Q16.8 coordinate
    localparam int DIFF_W  = COORD_W + 1;      // signed difference
    localparam int ABS_W   = COORD_W;          // absolute difference
    localparam int DIST_W  = 25;               // unsigned Q17.8 distance
    localparam int SQ_W    = 2 * ABS_W;        // one squared difference
    localparam int REM_W   = SQ_W + 1;         // sum of squares, partial remainder
    localparam int TRIAL_W = REM_W + 1;        // trial subtrahend of one root step
    localparam int ROOT_W  = DIST_W;           // bits of the integer square root

    localparam logic [1:0] METRIC_EUCLID = 2'd0;
    localparam logic [1:0] METRIC_MANH   = 2'd1;
    localparam logic [1:0] METRIC_CHEB   = 2'd2;
    localparam logic [1:0] METRIC_BAD    = 2'd3;

    // travels beside the root datapath
    typedef struct packed {
        logic              euc;   // take the square root as the result
        logic              bad;   // selector names no metric
        logic [DIST_W-1:0] alt;   // manhattan or chebyshev result, zero otherwise
    } pdu_side_t;

    typedef struct packed {
        logic              bad;
        logic [DIST_W-1:0] distance;
    } pdu_res_t;

endpackage

[rtl/core/planar_distance_unit.sv]
// Planar distance unit: Euclidean, Manhattan or Chebyshev distance between two Q16.8 points,
// giving an unsigned Q17.8 result; one request per clock while s_tready is high, passing through
// four front stages (difference, absolute value, square, sum), 25 square-root stages that
// each decide one root bit, and the output register. Selector 3 returns zero with the
// error flag in m_tuser. A stalled output holds one result plus one in the skid entry,
// after which s_tready drops until the output is taken.
// depends on pdu_pkg, pdu_front, pdu_sqrt_stage, pdu_skid
`timescale 1ns / 1ps

module planar_distance_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,    // ax[23:0], ay[47:24], bx[71:48], by[95:72]
    input  logic [1:0]  s_tuser,    // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // dist_res[24:0], zero fill [31:25]
    output logic [0:0]  m_tuser     // bad_metric[0]
);

    localparam int NSTAGE = pdu_pkg::ROOT_W;

    logic                       en;
    logic                       v_s    [0:NSTAGE];
    logic [pdu_pkg::REM_W-1:0]  rem_s  [0:NSTAGE];
    logic [pdu_pkg::ROOT_W-1:0] root_s [0:NSTAGE];
    pdu_pkg::pdu_side_t         side_s [0:NSTAGE];
    pdu_pkg::pdu_res_t          pipe_res;
    pdu_pkg::pdu_res_t          out_res;

    pdu_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_tvalid),
        .cmd       (s_tuser),
        .ax        (s_tdata[23:0]),
        .ay        (s_tdata[47:24]),
        .bx        (s_tdata[71:48]),
        .by        (s_tdata[95:72]),
        .out_valid (v_s[0]),
        .sum_sq    (rem_s[0]),
        .side      (side_s[0])
    );

    assign root_s[0] = '0;

    for (genvar k = 0; k < NSTAGE; k++) begin : g_root
        pdu_sqrt_stage #(
            .BIT (NSTAGE - 1 - k)
        ) u_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (v_s[k]),
            .rem_in    (rem_s[k]),
            .root_in   (root_s[k]),
            .side_in   (side_s[k]),
            .out_valid (v_s[k+1]),
            .rem_out   (rem_s[k+1]),
            .root_out  (root_s[k+1]),
            .side_out  (side_s[k+1])
        );
    end

    assign pipe_res.bad      = side_s[NSTAGE].bad;
    assign pipe_res.distance = side_s[NSTAGE].euc ? root_s[NSTAGE] : side_s[NSTAGE].alt;

    pdu_skid u_skid (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_valid (v_s[NSTAGE]),
        .pipe_res   (pipe_res),
        .pipe_en    (en),
        .m_valid    (m_tvalid),
        .m_ready    (m_tready),
        .m_res      (out_res)
    );

    assign s_tready = en;
    assign m_tdata  = {{(32 - pdu_pkg::DIST_W){1'b0}}, out_res.distance};
    assign m_tuser  = out_res.bad;

    // the error flag always comes with a zero distance
    a_bad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("invalid metric with nonzero distance");

endmodule

[rtl/core/pdu_front.sv]
// pdu_front: differences, absolute values, squares and sum of squares
// four register stages ahead of the root pipeline; non-euclidean results finish here
// depends on pdu_pkg
`timescale 1ns / 1ps

module pdu_front (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic [1:0]                         cmd,
    input  logic signed [pdu_pkg::COORD_W-1:0] ax,
    input  logic signed [pdu_pkg::COORD_W-1:0] ay,
    input  logic signed [pdu_pkg::COORD_W-1:0] bx,
    input  logic signed [pdu_pkg::COORD_W-1:0] by,
    output logic                               out_valid,
    output logic [pdu_pkg::REM_W-1:0]          sum_sq,
    output pdu_pkg::pdu_side_t                 side
);

    // stage 1: signed differences
    logic                               v1_reg;
    logic [1:0]                         cmd1_reg;
    logic signed [pdu_pkg::DIFF_W-1:0]  dx1_reg, dy1_reg;
    // stage 2: absolute differences
    logic                               v2_reg;
    logic [1:0]                         cmd2_reg;
    logic [pdu_pkg::ABS_W-1:0]          ax2_reg, ay2_reg;
    // stage 3: squares and the simple metrics
    logic                               v3_reg;
    logic [pdu_pkg::SQ_W-1:0]           sqx3_reg, sqy3_reg;
    pdu_pkg::pdu_side_t                 side3_reg, side3_next;
    // stage 4: sum of squares
    logic                               v4_reg;
    logic [pdu_pkg::REM_W-1:0]          sum4_reg;
    pdu_pkg::pdu_side_t                 side4_reg;

    logic [pdu_pkg::ABS_W-1:0]          ax_abs_next, ay_abs_next;

    assign ax_abs_next = dx1_reg[pdu_pkg::DIFF_W-1] ? pdu_pkg::ABS_W'(-dx1_reg)
                                                    : dx1_reg[pdu_pkg::ABS_W-1:0];
    assign ay_abs_next = dy1_reg[pdu_pkg::DIFF_W-1] ? pdu_pkg::ABS_W'(-dy1_reg)
                                                    : dy1_reg[pdu_pkg::ABS_W-1:0];

    always_comb begin
        side3_next.euc = (cmd2_reg == pdu_pkg::METRIC_EUCLID);
        side3_next.bad = (cmd2_reg == pdu_pkg::METRIC_BAD);
        unique case (cmd2_reg)
            pdu_pkg::METRIC_MANH: begin
                side3_next.alt = pdu_pkg::DIST_W'(ax2_reg) + pdu_pkg::DIST_W'(ay2_reg);
            end
            pdu_pkg::METRIC_CHEB: begin
                side3_next.alt = (ax2_reg > ay2_reg) ? pdu_pkg::DIST_W'(ax2_reg)
                                                     : pdu_pkg::DIST_W'(ay2_reg);
            end
            pdu_pkg::METRIC_EUCLID, pdu_pkg::METRIC_BAD: begin
                side3_next.alt = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= cmd;
            dx1_reg   <= pdu_pkg::DIFF_W'(bx) - pdu_pkg::DIFF_W'(ax);
            dy1_reg   <= pdu_pkg::DIFF_W'(by) - pdu_pkg::DIFF_W'(ay);
            cmd2_reg  <= cmd1_reg;
            ax2_reg   <= ax_abs_next;
            ay2_reg   <= ay_abs_next;
            sqx3_reg  <= ax2_reg * ax2_reg;
            sqy3_reg  <= ay2_reg * ay2_reg;
            side3_reg <= side3_next;
            sum4_reg  <= pdu_pkg::REM_W'(sqx3_reg) + pdu_pkg::REM_W'(sqy3_reg);
            side4_reg <= side3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign sum_sq    = sum4_reg;
    assign side      = side4_reg;

endmodule

[rtl/core/pdu_sqrt_stage.sv]
// pdu_sqrt_stage: one digit of the restoring integer square root
// decides root bit BIT with one compare and subtract; registered output
// depends on pdu_pkg
`timescale 1ns / 1ps

module pdu_sqrt_stage #(
    parameter int BIT = 0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pdu_pkg::REM_W-1:0]     rem_in,
    input  logic [pdu_pkg::ROOT_W-1:0]    root_in,
    input  pdu_pkg::pdu_side_t            side_in,
    output logic                          out_valid,
    output logic [pdu_pkg::REM_W-1:0]     rem_out,
    output logic [pdu_pkg::ROOT_W-1:0]    root_out,
    output pdu_pkg::pdu_side_t            side_out
);

    localparam logic [pdu_pkg::TRIAL_W-1:0] SQ_BIT  = pdu_pkg::TRIAL_W'(1) << (2 * BIT);
    localparam logic [pdu_pkg::ROOT_W-1:0]  ROOT_BIT = pdu_pkg::ROOT_W'(1) << BIT;

    logic                          valid_reg;
    logic [pdu_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [pdu_pkg::ROOT_W-1:0]    root_reg, root_next;
    pdu_pkg::pdu_side_t            side_reg;
    logic [pdu_pkg::TRIAL_W-1:0]   trial;
    logic                          fits;

    // (root + 2^bit)^2 - root^2 = root * 2^(bit+1) + 2^(2*bit)
    assign trial = (pdu_pkg::TRIAL_W'(root_in) << (BIT + 1)) + SQ_BIT;
    assign fits  = pdu_pkg::TRIAL_W'(rem_in) >= trial;

    always_comb begin
        if (fits) begin
            rem_next  = rem_in - trial[pdu_pkg::REM_W-1:0];
            root_next = root_in | ROOT_BIT;
        end else begin
            rem_next  = rem_in;
            root_next = root_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;

endmodule

[rtl/core/pdu_skid.sv]
// pdu_skid: output register with one skid entry
// decouples the pipeline enable from the downstream ready
// depends on pdu_pkg
`timescale 1ns / 1ps

module pdu_skid (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pipe_valid,
    input  pdu_pkg::pdu_res_t  pipe_res,
    output logic               pipe_en,
    output logic               m_valid,
    input  logic               m_ready,
    output pdu_pkg::pdu_res_t  m_res
);

    logic               out_valid_reg;
    pdu_pkg::pdu_res_t  out_res_reg;
    logic               skid_valid_reg;
    pdu_pkg::pdu_res_t  skid_res_reg;
    logic               take;
    logic               pipe_take;

    assign pipe_en   = !skid_valid_reg;
    assign take      = out_valid_reg && m_ready;
    assign pipe_take = pipe_valid && pipe_en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            priority if (!out_valid_reg || take) begin
                if (skid_valid_reg) begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end else begin
                    out_valid_reg <= pipe_take;
                end
            end else if (pipe_take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= skid_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take) begin
            out_res_reg <= skid_valid_reg ? skid_res_reg : pipe_res;
        end
        if (out_valid_reg && !take && pipe_take) begin
            skid_res_reg <= pipe_res;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_res   = out_res_reg;

    // skid entry only fills behind a held output
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    a_skid_fill_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready && pipe_valid))
        else $error("skid entry filled without a stalled output");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_valid_reg && m_ready) |=> !skid_valid_reg)
        else $error("skid entry not drained after output taken");

endmodule
